### src/fldq_pkg.sv
package fldq_pkg;

    // Defaults for the top-level parameters.
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TIME_BITS_DEF   = 48;

    // Fixed field widths.
    localparam int OP_W       = 2;
    localparam int NOW_W      = 48;
    localparam int TAG_W      = 16;
    localparam int SIZE_W     = 8;
    localparam int CSEL_W     = 3;
    localparam int KIND_W     = 2;
    localparam int LAT_W      = 48;
    localparam int CNT_W      = 64;
    localparam int ACC_LAT_W  = 24;
    localparam int LIMIT_W    = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;

    // A tick emits at most this many completed requests.
    localparam int MAX_RESULTS = 16;
    localparam int MR_W        = $clog2(MAX_RESULTS + 1);

    // Register reset values.
    localparam logic [ACC_LAT_W-1:0] ACC_LAT_RESET = ACC_LAT_W'(10000);
    localparam logic [LIMIT_W-1:0]   LIMIT_RESET   = '0;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_TICK  = 2'd1,
        OP_CREAD = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACK     = 2'd0,
        KIND_DONE    = 2'd1,
        KIND_COUNTER = 2'd2
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACCESS_LATENCY    = 1'b0,
        CFG_OUTSTANDING_LIMIT = 1'b1
    } cfg_index_t;

    // Statistic counter selects.
    localparam logic [CSEL_W-1:0] CSEL_READS       = 3'd0;
    localparam logic [CSEL_W-1:0] CSEL_WRITES      = 3'd1;
    localparam logic [CSEL_W-1:0] CSEL_BYTES_READ  = 3'd2;
    localparam logic [CSEL_W-1:0] CSEL_BYTES_WRITE = 3'd3;
    localparam logic [CSEL_W-1:0] CSEL_READ_LAT    = 3'd4;
    localparam logic [CSEL_W-1:0] CSEL_WRITE_LAT   = 3'd5;
    localparam logic [CSEL_W-1:0] CSEL_PEAK        = 3'd6;
    localparam logic [CSEL_W-1:0] CSEL_BUSY        = 3'd7;

    // One input request as it is latched.
    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [NOW_W-1:0]  now;
        logic [TAG_W-1:0]  request_tag;
        logic              write_req;
        logic              is_writeback;
        logic [SIZE_W-1:0] data_size;
        logic [CSEL_W-1:0] counter_select;
    } req_item_t;

    // One result, less the occupancy whose width follows the queue depth.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              accepted;
        logic [TAG_W-1:0]  done_tag;
        logic              done_write;
        logic              is_reply;
        logic [LAT_W-1:0]  measured_latency;
        logic [CNT_W-1:0]  counter_value;
        logic              is_full;
        logic              last;
    } rsp_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;
        logic push;
        logic cread;
        logic tick;
        logic pop;
        logic flush;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [OP_W-1:0] req_opcode;
        logic            occ_zero;
        logic            due;
        logic            out_free;
        logic            pop_last;
        logic            pend_valid;
    } dp_sts_t;

endpackage

### src/fldq_if.sv
interface fldq_req_if;
    import fldq_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [NOW_W-1:0]  now;
    logic [TAG_W-1:0]  request_tag;
    logic              write_req;
    logic              is_writeback;
    logic [SIZE_W-1:0] data_size;
    logic [CSEL_W-1:0] counter_select;

    modport source (
        output valid, opcode, now, request_tag, write_req, is_writeback, data_size,
               counter_select,
        input  ready
    );

    modport sink (
        input  valid, opcode, now, request_tag, write_req, is_writeback, data_size,
               counter_select,
        output ready
    );
endinterface

interface fldq_rsp_if #(
    parameter int OCC_W = $clog2(fldq_pkg::QUEUE_DEPTH_DEF + 1)
);
    import fldq_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic              accepted;
    logic [TAG_W-1:0]  done_tag;
    logic              done_write;
    logic              is_reply;
    logic [LAT_W-1:0]  measured_latency;
    logic [CNT_W-1:0]  counter_value;
    logic [OCC_W-1:0]  occupancy;
    logic              is_full;
    logic              last;

    modport source (
        output valid, kind, accepted, done_tag, done_write, is_reply,
               measured_latency, counter_value, occupancy, is_full, last,
        input  ready
    );

    modport sink (
        input  valid, kind, accepted, done_tag, done_write, is_reply,
               measured_latency, counter_value, occupancy, is_full, last,
        output ready
    );
endinterface

interface fldq_cfg_if;
    import fldq_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

### src/fldq_ram.sv
module fldq_ram #(
    parameter int WIDTH = 66,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

### src/fldq_ctrl.sv
module fldq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  fldq_pkg::dp_sts_t  sts,
    output fldq_pkg::ctl_cmd_t cmd
);
    import fldq_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PUSH  = 7'b0000010,
        S_CREAD = 7'b0000100,
        S_TICK  = 7'b0001000,
        S_EVAL  = 7'b0010000,
        S_FETCH = 7'b0100000,
        S_FLUSH = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // A new request is taken only while the sequencer is idle.
    assign in_ready = (state_reg == S_IDLE);

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch = 1'b1;
                    case (sts.req_opcode)
                        OP_PUSH:  state_next = S_PUSH;
                        OP_TICK:  state_next = S_TICK;
                        OP_CREAD: state_next = S_CREAD;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_PUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_CREAD:
            begin
                if (sts.out_free)
                begin
                    cmd.cread  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_TICK:
            begin
                cmd.tick   = 1'b1;
                state_next = sts.occ_zero ? S_IDLE : S_EVAL;
            end
            S_EVAL:
            begin
                // A due head is popped into the pending slot; the previous
                // pending entry goes out first, so it needs a free output.
                if (sts.due)
                begin
                    if (!sts.pend_valid || sts.out_free)
                    begin
                        cmd.pop    = 1'b1;
                        state_next = sts.pop_last ? S_FLUSH : S_FETCH;
                    end
                end
                else
                begin
                    state_next = sts.pend_valid ? S_FLUSH : S_IDLE;
                end
            end
            S_FETCH:
            begin
                // Wait for the read of the new head.
                state_next = S_EVAL;
            end
            S_FLUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

### src/fldq_dp.sv
module fldq_dp #(
    parameter int QUEUE_DEPTH = fldq_pkg::QUEUE_DEPTH_DEF,
    parameter int TIME_BITS   = fldq_pkg::TIME_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fldq_pkg::ctl_cmd_t                  cmd,
    output fldq_pkg::dp_sts_t                   sts,
    input  fldq_pkg::req_item_t                 req_item,
    input  logic                                cfg_we,
    input  logic [fldq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fldq_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output fldq_pkg::rsp_item_t                 out_item,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]    out_occupancy
);
    import fldq_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W = (TIME_BITS > NOW_W) ? TIME_BITS : NOW_W;
    localparam int ENT_W = TIME_BITS + TAG_W + 2;

    // Configuration.
    logic [ACC_LAT_W-1:0] acc_lat_reg;
    logic [LIMIT_W-1:0]   limit_reg;

    // Queue control.
    req_item_t        item_reg;
    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] tail_reg;
    logic [OCC_W-1:0] occ_reg;
    logic [MR_W-1:0]  n_reg;

    // Statistics.
    logic [CNT_W-1:0] read_count_reg;
    logic [CNT_W-1:0] write_count_reg;
    logic [CNT_W-1:0] bytes_read_reg;
    logic [CNT_W-1:0] bytes_written_reg;
    logic [CNT_W-1:0] read_lat_sum_reg;
    logic [CNT_W-1:0] write_lat_sum_reg;
    logic [OCC_W-1:0] peak_reg;
    logic [CNT_W-1:0] busy_reg;

    // Popped entry held until it is known whether it is the last one.
    rsp_item_t        pend_item_reg;
    logic [OCC_W-1:0] pend_occ_reg;
    logic             lat_add_reg;

    // Output register.
    logic             out_valid_reg;
    rsp_item_t        out_item_reg;
    logic [OCC_W-1:0] out_occ_reg;

    // Combinational values.
    logic                 lim_gt;
    logic [OCC_W-1:0]     cur_limit;
    logic                 full_now;
    logic                 push_ok;
    logic [OCC_W-1:0]     occ_push;
    logic [OCC_W-1:0]     occ_pop;
    logic [MR_W-1:0]      n_next;
    logic [CMP_W:0]       ready_sum;
    logic [TIME_BITS-1:0] ready_time;
    logic [ENT_W-1:0]     ram_wdata;
    logic [ENT_W-1:0]     ram_rdata;
    logic [TIME_BITS-1:0] rd_ready;
    logic [TIME_BITS-1:0] lat_ext;
    logic [TIME_BITS-1:0] pushed;
    logic [LAT_W-1:0]     meas_lat;
    logic [CNT_W-1:0]     counter_sel;
    logic                 out_load;
    rsp_item_t            out_item_next;
    logic [OCC_W-1:0]     out_occ_next;
    rsp_item_t            pop_item;
    logic [IDX_W-1:0]     head_inc;
    logic [IDX_W-1:0]     tail_inc;

    // Effective limit: zero or anything above the depth means the depth.
    assign lim_gt    = 8'(limit_reg) > 8'(QUEUE_DEPTH);
    assign cur_limit = ((limit_reg == '0) || lim_gt) ? OCC_W'(QUEUE_DEPTH)
                                                     : OCC_W'(limit_reg);
    assign full_now  = occ_reg >= cur_limit;
    assign push_ok   = !full_now;
    assign occ_push  = occ_reg + OCC_W'(1);
    assign occ_pop   = occ_reg - OCC_W'(1);
    assign n_next    = n_reg + MR_W'(1);

    // Circular pointers for any depth.
    assign head_inc = (head_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + IDX_W'(1);
    assign tail_inc = (tail_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + IDX_W'(1);

    // Ready time, saturated at the largest time value.
    assign ready_sum  = (CMP_W + 1)'(item_reg.now) + (CMP_W + 1)'(acc_lat_reg);
    assign ready_time = ((ready_sum >> TIME_BITS) != '0) ? '1
                                                         : ready_sum[TIME_BITS-1:0];
    assign ram_wdata  = {ready_time, item_reg.is_writeback, item_reg.write_req,
                         item_reg.request_tag};

    fldq_ram #(
        .WIDTH (ENT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.push && push_ok),
        .waddr (tail_reg),
        .wdata (ram_wdata),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    // Head entry decode and measured latency.
    assign rd_ready = ram_rdata[ENT_W-1 -: TIME_BITS];
    assign lat_ext  = TIME_BITS'(acc_lat_reg);
    assign pushed   = (rd_ready >= lat_ext) ? (rd_ready - lat_ext) : '0;
    assign meas_lat = item_reg.now - LAT_W'(pushed);

    always_comb
    begin
        pop_item                  = '0;
        pop_item.kind             = KIND_DONE;
        pop_item.done_tag         = ram_rdata[TAG_W-1:0];
        pop_item.done_write       = ram_rdata[TAG_W];
        pop_item.is_reply         = !ram_rdata[TAG_W+1];
        pop_item.measured_latency = meas_lat;
        pop_item.is_full          = occ_pop >= cur_limit;
        pop_item.last             = 1'b0;
    end

    // Status to the controller.
    assign sts.req_opcode = req_item.opcode;
    assign sts.occ_zero   = (occ_reg == '0);
    assign sts.due        = CMP_W'(item_reg.now) >= CMP_W'(rd_ready);
    assign sts.out_free   = !out_valid_reg || out_ready;
    assign sts.pop_last   = (occ_pop == '0) || (n_next == MR_W'(MAX_RESULTS));
    assign sts.pend_valid = (n_reg != '0);

    // Statistic counter selection.
    always_comb
    begin
        case (item_reg.counter_select)
            CSEL_READS:       counter_sel = read_count_reg;
            CSEL_WRITES:      counter_sel = write_count_reg;
            CSEL_BYTES_READ:  counter_sel = bytes_read_reg;
            CSEL_BYTES_WRITE: counter_sel = bytes_written_reg;
            CSEL_READ_LAT:    counter_sel = read_lat_sum_reg;
            CSEL_WRITE_LAT:   counter_sel = write_lat_sum_reg;
            CSEL_PEAK:        counter_sel = CNT_W'(peak_reg);
            CSEL_BUSY:        counter_sel = busy_reg;
            default:          counter_sel = busy_reg;
        endcase
    end

    // Output register load.
    always_comb
    begin
        out_load      = 1'b0;
        out_item_next = '0;
        out_occ_next  = '0;
        if (cmd.push)
        begin
            out_load               = 1'b1;
            out_item_next.kind     = KIND_ACK;
            out_item_next.accepted = push_ok;
            out_item_next.is_full  = push_ok ? (occ_push >= cur_limit) : 1'b1;
            out_item_next.last     = 1'b1;
            out_occ_next           = push_ok ? occ_push : occ_reg;
        end
        else if (cmd.cread)
        begin
            out_load                    = 1'b1;
            out_item_next.kind          = KIND_COUNTER;
            out_item_next.counter_value = counter_sel;
            out_item_next.is_full       = full_now;
            out_item_next.last          = 1'b1;
            out_occ_next                = occ_reg;
        end
        else if (cmd.flush || (cmd.pop && sts.pend_valid))
        begin
            out_load           = 1'b1;
            out_item_next      = pend_item_reg;
            out_item_next.last = cmd.flush;
            out_occ_next       = pend_occ_reg;
        end
    end

    // Request latch, pending entry and output payload.
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            item_reg <= req_item;
        end
        if (cmd.pop)
        begin
            pend_item_reg <= pop_item;
            pend_occ_reg  <= occ_pop;
        end
        if (out_load)
        begin
            out_item_reg <= out_item_next;
            out_occ_reg  <= out_occ_next;
        end
    end

    // Configuration, queue control and statistics.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_lat_reg       <= ACC_LAT_RESET;
            limit_reg         <= LIMIT_RESET;
            head_reg          <= '0;
            tail_reg          <= '0;
            occ_reg           <= '0;
            n_reg             <= '0;
            read_count_reg    <= '0;
            write_count_reg   <= '0;
            bytes_read_reg    <= '0;
            bytes_written_reg <= '0;
            read_lat_sum_reg  <= '0;
            write_lat_sum_reg <= '0;
            peak_reg          <= '0;
            busy_reg          <= '0;
            lat_add_reg       <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ACCESS_LATENCY:    acc_lat_reg <= cfg_data[ACC_LAT_W-1:0];
                    CFG_OUTSTANDING_LIMIT: limit_reg   <= cfg_data[LIMIT_W-1:0];
                    default:               limit_reg   <= limit_reg;
                endcase
            end

            // Accepted push: store at the tail and count it.
            if (cmd.push && push_ok)
            begin
                tail_reg <= tail_inc;
                occ_reg  <= occ_push;
                if (item_reg.write_req)
                begin
                    write_count_reg   <= write_count_reg + CNT_W'(1);
                    bytes_written_reg <= bytes_written_reg + CNT_W'(item_reg.data_size);
                end
                else
                begin
                    read_count_reg <= read_count_reg + CNT_W'(1);
                    bytes_read_reg <= bytes_read_reg + CNT_W'(item_reg.data_size);
                end
                if (occ_push > peak_reg)
                begin
                    peak_reg <= occ_push;
                end
            end

            // Tick start: count a busy cycle and reset the emit count.
            if (cmd.tick)
            begin
                n_reg <= '0;
                if (occ_reg != '0)
                begin
                    busy_reg <= busy_reg + CNT_W'(1);
                end
            end

            // Pop of a due head entry.
            if (cmd.pop)
            begin
                head_reg <= head_inc;
                occ_reg  <= occ_pop;
                n_reg    <= n_next;
            end

            // Latency sum of the entry popped in the previous cycle.
            lat_add_reg <= cmd.pop;
            if (lat_add_reg)
            begin
                if (pend_item_reg.done_write)
                begin
                    write_lat_sum_reg <= write_lat_sum_reg
                                         + CNT_W'(pend_item_reg.measured_latency);
                end
                else
                begin
                    read_lat_sum_reg <= read_lat_sum_reg
                                        + CNT_W'(pend_item_reg.measured_latency);
                end
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_item      = out_item_reg;
    assign out_occupancy = out_occ_reg;
endmodule

### src/fixed_latency_request_delay_queue.sv
// Fixed-latency request delay queue.
// The req channel carries one operation per request: a push of a memory request,
// a tick that drains expired entries at the given cycle number, or a read of
// one statistic counter. The rsp channel returns the results; cfg writes the
// CFG_ACCESS_LATENCY and CFG_OUTSTANDING_LIMIT registers. The user is to
// write them only while idle; the block itself does not enforce this.
// A push is latched, then offers one acknowledge from the output register once
// that register is free; an accepted push stores the ready time now + access
// latency in a queue memory. A counter read offers its value the same way.
// A tick emits at most 16 entries and stops on an empty queue, the sixteenth
// entry or an entry not yet due: each head is read from the registered-read
// memory before its due check, and each popped entry is held until it is
// known whether it is the last one, which is then flagged.
// A new request is taken only after the previous one is fully handled.
// Reset empties the queue, clears all counters and loads the register
// defaults; no clearing pass is needed. When the receiver stalls, the output
// register holds the result and the sequencer waits before the next one.
module fixed_latency_request_delay_queue #(
    parameter int QUEUE_DEPTH = fldq_pkg::QUEUE_DEPTH_DEF,
    parameter int TIME_BITS   = fldq_pkg::TIME_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    fldq_req_if.sink        req,
    fldq_rsp_if.source      rsp,
    fldq_cfg_if.sink        cfg
);
    import fldq_pkg::*;

    ctl_cmd_t  cmd;
    dp_sts_t   sts;
    req_item_t req_item;
    rsp_item_t out_item;

    // Request payload packing.
    assign req_item.opcode         = req.opcode;
    assign req_item.now            = req.now;
    assign req_item.request_tag    = req.request_tag;
    assign req_item.write_req      = req.write_req;
    assign req_item.is_writeback   = req.is_writeback;
    assign req_item.data_size      = req.data_size;
    assign req_item.counter_select = req.counter_select;

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;

    fldq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fldq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TIME_BITS   (TIME_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .req_item      (req_item),
        .cfg_we        (cfg.valid),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .out_valid     (rsp.valid),
        .out_ready     (rsp.ready),
        .out_item      (out_item),
        .out_occupancy (rsp.occupancy)
    );

    // Result payload unpacking.
    assign rsp.kind             = out_item.kind;
    assign rsp.accepted         = out_item.accepted;
    assign rsp.done_tag         = out_item.done_tag;
    assign rsp.done_write       = out_item.done_write;
    assign rsp.is_reply         = out_item.is_reply;
    assign rsp.measured_latency = out_item.measured_latency;
    assign rsp.counter_value    = out_item.counter_value;
    assign rsp.is_full          = out_item.is_full;
    assign rsp.last             = out_item.last;
endmodule

### src/fldq_checker.sv
module fldq_checker #(
    parameter int QUEUE_DEPTH = fldq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            rsp_valid,
    input  logic                            rsp_ready,
    input  logic [fldq_pkg::KIND_W-1:0]     kind,
    input  logic                            accepted,
    input  logic [fldq_pkg::TAG_W-1:0]      done_tag,
    input  logic [fldq_pkg::CNT_W-1:0]      counter_value,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0] occupancy,
    input  logic                            is_full,
    input  logic                            last
);
    import fldq_pkg::*;

    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

    // A stalled result stays offered and unchanged.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(kind) && $stable(done_tag)
            && $stable(counter_value) && $stable(last))
        else $error("stalled result changed");

    // Acknowledges and counter values are single results.
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (kind == KIND_ACK || kind == KIND_COUNTER) |-> last)
        else $error("single result without last");

    // A refused push is only possible against a full queue.
    a_refused_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && kind == KIND_ACK && !accepted |-> is_full)
        else $error("push refused while not full");

    // A queue at its depth always reports full.
    a_depth_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && occupancy == OCC_W'(QUEUE_DEPTH) |-> is_full)
        else $error("queue at depth not reported full");
endmodule

bind fixed_latency_request_delay_queue fldq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_fldq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .kind          (rsp.kind),
    .accepted      (rsp.accepted),
    .done_tag      (rsp.done_tag),
    .counter_value (rsp.counter_value),
    .occupancy     (rsp.occupancy),
    .is_full       (rsp.is_full),
    .last          (rsp.last)
);
